// ===== src/rlcsp_pkg.sv =====
// Shared types and constants for the RLC STATUS PDU parser.
package rlcsp_pkg;

   // Result kind codes
   localparam logic [2:0] KIND_ACK   = 3'd0;
   localparam logic [2:0] KIND_NACK  = 3'd1;
   localparam logic [2:0] KIND_DATA  = 3'd2;
   localparam logic [2:0] KIND_OTHER = 3'd3;
   localparam logic [2:0] KIND_TRUNC = 3'd4;

   // Record sizes in bits
   localparam logic [6:0] HDR_BITS        = 7'd24;
   localparam logic [6:0] NACK_SHORT_BITS = 7'd16;
   localparam logic [6:0] NACK_LONG_BITS  = 7'd24;
   localparam logic [6:0] SO_PAIR_BITS    = 7'd32;
   localparam logic [6:0] RANGE_BITS      = 7'd8;

   // Result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic [2:0]  kind;
      logic [17:0] seq_num;
      logic        so_valid;
      logic [15:0] so_start;
      logic [15:0] so_end;
      logic        range_valid;
      logic [7:0]  nack_range;
      logic        final_record;
   } result_type;

   localparam result_type RES_NONE = '0;

endpackage

// ===== src/rlc_status_pdu_parser.sv =====
// RLC STATUS control PDU parser: octet stream in, ack header and nack block records out.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  pdu_byte, pdu_end
//   rsp_      out        rsp_valid / rsp_stall  kind, seq_num, so_*, range_*, final_record
//   csr_      in         csr_wr_en              sn_mode (csr_wr_data)
//
// One octet is taken per cycle while req_stall is low; its parse finishes in the cycle it
// is taken and its results (at most two) land in a four-entry result queue that is read
// out one per cycle while rsp_stall is low. req_stall rises while the queue has fewer
// than two free entries. Synchronous reset returns the parser to expect a first header
// octet, empties the queue and selects 12-bit sequence numbers.
module rlc_status_pdu_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pdu_byte,
   input  logic        req_pdu_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [17:0] rsp_seq_num,
   output logic        rsp_so_valid,
   output logic [15:0] rsp_so_start,
   output logic [15:0] rsp_so_end,
   output logic        rsp_range_valid,
   output logic [7:0]  rsp_nack_range,
   output logic        rsp_final_record
);

   // Parse phase codes
   localparam logic [2:0] PH_FIRST  = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_NACK   = 3'd2;
   localparam logic [2:0] PH_TAIL   = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;

   localparam int PTR_W = rlcsp_pkg::RSP_PTR_W;
   localparam int CNT_W = rlcsp_pkg::RSP_PTR_W + 1;
   localparam logic [CNT_W-1:0] STALL_LEVEL = CNT_W'(rlcsp_pkg::RSP_DEPTH - 2);

   logic [2:0]  phase_ff, phase_in;
   logic [63:0] store_ff, store_in;
   logic [6:0]  held_ff, held_in;
   logic [6:0]  need_ff, need_in;
   logic [2:0]  ext_ff, ext_in;
   logic        long_ff, long_in;
   logic        mode_ff;

   rlcsp_pkg::result_type queue_ff [rlcsp_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   logic       req_take, rsp_take;
   logic [1:0] push_cnt;
   rlcsp_pkg::result_type res_a, res_b;

   logic [63:0] shift_store;
   logic [6:0]  shift_held;
   logic [17:0] hdr_sn;
   logic        hdr_e1;
   logic [2:0]  nack_ext, blk_ext;
   logic [6:0]  fixed_bits;
   logic [63:0] blk_shifted, blk_so_src;
   rlcsp_pkg::result_type hdr_res, blk_res;

   assign req_take = req_valid & ~req_stall;
   assign rsp_take = rsp_valid & ~rsp_stall;
   assign req_stall = (count_ff > STALL_LEVEL);

   // Append the new octet to the record under assembly
   assign shift_store = {store_ff[55:0], req_pdu_byte};
   assign shift_held  = held_ff + 7'd8;
   assign fixed_bits  = long_ff ? rlcsp_pkg::NACK_LONG_BITS : rlcsp_pkg::NACK_SHORT_BITS;

   // Decode the ack header: ACK_SN then E1
   always_comb begin
      if (long_ff) begin
         hdr_sn = shift_store[19:2];
         hdr_e1 = shift_store[1];
      end else begin
         hdr_sn = {6'd0, shift_store[19:8]};
         hdr_e1 = shift_store[7];
      end
      hdr_res = rlcsp_pkg::RES_NONE;
      hdr_res.kind = rlcsp_pkg::KIND_ACK;
      hdr_res.seq_num = hdr_sn;
      hdr_res.final_record = ~hdr_e1;
   end

   // Decode a nack block; optional fields sit below the fixed part
   assign nack_ext = long_ff ? shift_store[5:3] : shift_store[3:1];
   assign blk_ext  = (phase_ff == PH_NACK) ? nack_ext : ext_ff;

   always_comb begin
      unique case (blk_ext[1:0])
         2'b00: blk_shifted = shift_store;
         2'b01: blk_shifted = shift_store >> 8;
         2'b10: blk_shifted = shift_store >> 32;
         2'b11: blk_shifted = shift_store >> 40;
         default: blk_shifted = shift_store;
      endcase
      blk_so_src = blk_ext[0] ? (shift_store >> 8) : shift_store;
      blk_res = rlcsp_pkg::RES_NONE;
      blk_res.kind = rlcsp_pkg::KIND_NACK;
      blk_res.seq_num = long_ff ? blk_shifted[23:6] : {6'd0, blk_shifted[15:4]};
      blk_res.so_valid = blk_ext[1];
      blk_res.so_start = blk_ext[1] ? blk_so_src[31:16] : 16'd0;
      blk_res.so_end = blk_ext[1] ? blk_so_src[15:0] : 16'd0;
      blk_res.range_valid = blk_ext[0];
      blk_res.nack_range = blk_ext[0] ? shift_store[7:0] : 8'd0;
      blk_res.final_record = ~blk_ext[2];
   end

   // Advance the parser by one octet and collect its results
   always_comb begin
      logic                  mid_valid;
      rlcsp_pkg::result_type mid_res;
      rlcsp_pkg::result_type trunc_res;

      phase_in = phase_ff;
      store_in = store_ff;
      held_in = held_ff;
      need_in = need_ff;
      ext_in = ext_ff;
      long_in = long_ff;
      mid_valid = 1'b0;
      mid_res = rlcsp_pkg::RES_NONE;
      trunc_res = rlcsp_pkg::RES_NONE;
      trunc_res.kind = rlcsp_pkg::KIND_TRUNC;
      trunc_res.final_record = 1'b1;
      res_a = rlcsp_pkg::RES_NONE;
      res_b = rlcsp_pkg::RES_NONE;
      push_cnt = 2'd0;

      if (req_take) begin
         unique case (phase_ff)
            PH_FIRST: begin
               long_in = mode_ff;
               store_in = 64'd0;
               held_in = 7'd0;
               need_in = 7'd0;
               ext_in = 3'd0;
               mid_res.final_record = 1'b1;
               if (req_pdu_byte[7]) begin
                  mid_valid = 1'b1;
                  mid_res.kind = rlcsp_pkg::KIND_DATA;
                  phase_in = PH_SKIP;
               end else if (req_pdu_byte[6:4] != 3'd0) begin
                  mid_valid = 1'b1;
                  mid_res.kind = rlcsp_pkg::KIND_OTHER;
                  phase_in = PH_SKIP;
               end else begin
                  store_in = {56'd0, req_pdu_byte};
                  held_in = 7'd8;
                  need_in = rlcsp_pkg::HDR_BITS;
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER, PH_NACK, PH_TAIL: begin
               store_in = shift_store;
               held_in = shift_held;
               if (shift_held >= need_ff) begin
                  if (phase_ff == PH_HEADER) begin
                     mid_valid = 1'b1;
                     mid_res = hdr_res;
                     store_in = 64'd0;
                     held_in = 7'd0;
                     ext_in = {hdr_e1, 2'b00};
                     need_in = hdr_e1 ? fixed_bits : 7'd0;
                     phase_in = hdr_e1 ? PH_NACK : PH_SKIP;
                  end else if (phase_ff == PH_NACK && nack_ext[1:0] != 2'b00) begin
                     // wait for the segment offsets, the range, or both
                     ext_in = nack_ext;
                     need_in = need_ff
                             + (nack_ext[1] ? rlcsp_pkg::SO_PAIR_BITS : 7'd0)
                             + (nack_ext[0] ? rlcsp_pkg::RANGE_BITS : 7'd0);
                     phase_in = PH_TAIL;
                  end else begin
                     mid_valid = 1'b1;
                     mid_res = blk_res;
                     store_in = 64'd0;
                     held_in = 7'd0;
                     ext_in = blk_ext;
                     need_in = blk_ext[2] ? fixed_bits : 7'd0;
                     phase_in = blk_ext[2] ? PH_NACK : PH_SKIP;
                  end
               end
            end
            default: phase_in = PH_SKIP;
         endcase

         res_a = mid_res;
         push_cnt = {1'b0, mid_valid};

         // Close the PDU; flag a record cut short
         if (req_pdu_end) begin
            if (phase_in != PH_SKIP && phase_in != PH_FIRST) begin
               if (mid_valid) begin
                  res_b = trunc_res;
                  push_cnt = 2'd2;
               end else begin
                  res_a = trunc_res;
                  push_cnt = 2'd1;
               end
            end
            phase_in = PH_FIRST;
            store_in = 64'd0;
            held_in = 7'd0;
            need_in = 7'd0;
            ext_in = 3'd0;
         end
      end
   end

   // Hold parser state and the sequence number mode
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         store_ff <= 64'd0;
         held_ff <= 7'd0;
         need_ff <= 7'd0;
         ext_ff <= 3'd0;
         long_ff <= 1'b0;
         mode_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         store_ff <= store_in;
         held_ff <= held_in;
         need_ff <= need_in;
         ext_ff <= ext_in;
         long_ff <= long_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   // Write results into the queue in order
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res_a;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= res_b;
      end
   end

   // Advance queue pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(rsp_take);
         count_ff <= count_ff + CNT_W'(push_cnt) - CNT_W'(rsp_take);
      end
   end

   // Present the oldest result; it holds until its transfer
   assign rsp_valid        = (count_ff != '0);
   assign rsp_kind         = queue_ff[rd_ptr_ff].kind;
   assign rsp_seq_num      = queue_ff[rd_ptr_ff].seq_num;
   assign rsp_so_valid     = queue_ff[rd_ptr_ff].so_valid;
   assign rsp_so_start     = queue_ff[rd_ptr_ff].so_start;
   assign rsp_so_end       = queue_ff[rd_ptr_ff].so_end;
   assign rsp_range_valid  = queue_ff[rd_ptr_ff].range_valid;
   assign rsp_nack_range   = queue_ff[rd_ptr_ff].nack_range;
   assign rsp_final_record = queue_ff[rd_ptr_ff].final_record;

endmodule
